// ===== rtl/ckmd_pkg.sv =====
// shared types and constants for the color keyed 2x2 mipmap downsampler
// no dependencies; imported by color_keyed_mipmap_downsample and tb_top
`default_nettype none

package ckmd_pkg;

   // pixel and channel widths of the rgb555 format
   localparam int PIXEL_W = 16;
   localparam int CHAN_W  = 5;
   localparam int CSR_W   = 9;
   localparam int IDX_W   = 2;
   localparam int PAIRS_W = 8;
   localparam int ROWS_W  = 9;
   localparam int ROWCNT_W = 8;

   // largest row count of one image
   localparam logic [ROWS_W-1:0] ROWS_MAX = 9'd256;

   // register reset values
   localparam logic                HARD_MODE_RST = 1'b1;
   localparam logic [PAIRS_W-1:0]  PAIRS_RST     = 8'd128;
   localparam logic [ROWS_W-1:0]   ROWS_RST      = 9'd128;

   // configuration register indexes
   typedef enum logic [IDX_W-1:0] {
      CSR_HARD_MODE     = 2'd0,
      CSR_PAIRS_PER_ROW = 2'd1,
      CSR_OUT_ROWS      = 2'd2
   } csr_index_type;

   // payload carried from the accept stage to the averaging stage
   typedef struct packed {
      logic [PIXEL_W-1:0] lower_left;
      logic [PIXEL_W-1:0] lower_right;
      logic               last_row;
      logic               last_image;
      logic               hard;
   } block_type;

endpackage : ckmd_pkg

`default_nettype wire

// ===== rtl/color_keyed_mipmap_downsample.sv =====
// 2x2 box downsampler for rgb555 pixels with a zero color key
// depends on ckmd_pkg; holds the line buffer memory and the averaging stage
// an accepted lower-right word fills the stage register, then the output register
// throughput: one source word per clock unless rsp stalls with the stage full
// the output register and one stage register buffer two results while rsp is stalled
// reset (synchronous, active high) clears counters, parity, the left pixel and
// the registers; the line buffer is not cleared and holds garbage until written
`default_nettype none

module color_keyed_mipmap_downsample #(
   parameter int LINE_WIDTH = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // source stream
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [ckmd_pkg::PIXEL_W-1:0] req_tdata,   // [15:0] src_pixel
   // result stream
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [ckmd_pkg::PIXEL_W-1:0]     rsp_tdata,   // [15:0] mip_pixel
   output logic                             rsp_tlast,   // last_in_row
   output logic [0:0]                       rsp_tuser,   // [0] last_in_image
   // configuration writes
   input  wire logic                        csr_wen,
   input  wire logic [ckmd_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [ckmd_pkg::CSR_W-1:0]  csr_wdata
);
   import ckmd_pkg::*;

   localparam int HALF = LINE_WIDTH / 2;
   localparam int AW   = $clog2(LINE_WIDTH);
   localparam int CW   = $clog2(LINE_WIDTH + 1);
   localparam int PW   = $clog2(HALF + 1);

   // configuration registers
   logic                hard_ff;
   logic [PAIRS_W-1:0]  pairs_ff;
   logic [ROWS_W-1:0]   rows_ff;

   // position state
   logic [CW-1:0]       col_ff, col_in;
   logic                parity_ff, parity_in;
   logic [ROWCNT_W-1:0] row_ff, row_in;
   logic [PIXEL_W-1:0]  left_ff, left_in;

   // stage and output registers
   logic                s1_valid_ff, s1_valid_in;
   block_type           s1_ff, s1_in;
   logic                rsp_valid_ff;
   logic [PIXEL_W-1:0]  rsp_data_ff;
   logic                rsp_last_ff;
   logic                rsp_user_ff;

   // line buffer
   logic [PIXEL_W-1:0]  line_mem [LINE_WIDTH];
   logic [PIXEL_W-1:0]  rd_left_ff, rd_right_ff;

   logic                acc, advance, is_result, mem_wr, lr, li;
   logic [PW-1:0]       pairs_eff;
   logic [CW-1:0]       width_eff, col_eff, col_next;
   logic [ROWS_W-1:0]   rows_eff, row_plus;

   // rounded 2x2 average with the color key rules
   function automatic logic [PIXEL_W-1:0] block_avg(
      input logic [PIXEL_W-1:0] a,
      input logic [PIXEL_W-1:0] b,
      input logic [PIXEL_W-1:0] c,
      input logic [PIXEL_W-1:0] d,
      input logic               hard
   );
      logic [PIXEL_W-1:0]  p1, p2, p3, p4, res;
      logic [CHAN_W+1:0]   sb, sg, sr;
      logic [3*CHAN_W-1:0] v;
      p1 = hard ? a : {1'b0, a[PIXEL_W-1:1]};
      p2 = hard ? b : {1'b0, b[PIXEL_W-1:1]};
      p3 = hard ? c : {1'b0, c[PIXEL_W-1:1]};
      p4 = hard ? d : {1'b0, d[PIXEL_W-1:1]};
      if (p2 == '0) p2 = p1;
      if (p3 == '0) p3 = p1;
      if (p4 == '0) p4 = p1;
      sb = {2'b00, p1[4:0]} + {2'b00, p2[4:0]} + {2'b00, p3[4:0]}
         + {2'b00, p4[4:0]} + 7'd2;
      sg = {2'b00, p1[9:5]} + {2'b00, p2[9:5]} + {2'b00, p3[9:5]}
         + {2'b00, p4[9:5]} + 7'd2;
      sr = {2'b00, p1[14:10]} + {2'b00, p2[14:10]} + {2'b00, p3[14:10]}
         + {2'b00, p4[14:10]} + 7'd2;
      v = {sr[CHAN_W+1:2], sg[CHAN_W+1:2], sb[CHAN_W+1:2]};
      res = hard ? {1'b0, v} : {v, 1'b0};
      if (p1 == '0) res = '0;
      return res;
   endfunction

   // effective geometry from the registers
   always_comb begin
      if (pairs_ff == '0) pairs_eff = PW'(1);
      else if (pairs_ff > HALF) pairs_eff = PW'(HALF);
      else pairs_eff = PW'(pairs_ff);
      width_eff = CW'({pairs_eff, 1'b0});
      if (rows_ff == '0) rows_eff = ROWS_W'(1);
      else if (rows_ff > ROWS_MAX) rows_eff = ROWS_MAX;
      else rows_eff = rows_ff;
   end

   // handshake
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign acc        = req_tvalid && req_tready;

   // position bookkeeping and result decision
   always_comb begin
      col_eff   = (col_ff >= width_eff) ? '0 : col_ff;
      is_result = parity_ff && col_eff[0];
      mem_wr    = acc && !parity_ff;
      lr        = (CW'(col_eff[CW-1:1]) + CW'(1)) == CW'(pairs_eff);
      row_plus  = {1'b0, row_ff} + ROWS_W'(1);
      li        = lr && (row_plus >= rows_eff);
      col_next  = col_eff + CW'(1);

      col_in    = col_ff;
      parity_in = parity_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      if (acc) begin
         if (parity_ff && !col_eff[0]) left_in = req_tdata;
         col_in = col_next;
         if (col_next >= width_eff) begin
            col_in    = '0;
            parity_in = !parity_ff;
            if (parity_ff) row_in = (row_plus >= rows_eff) ? '0 : row_plus[ROWCNT_W-1:0];
         end
      end

      s1_in.lower_left  = left_ff;
      s1_in.lower_right = req_tdata;
      s1_in.last_row    = lr;
      s1_in.last_image  = li;
      s1_in.hard        = hard_ff;
      if (acc && is_result) s1_valid_in = 1'b1;
      else if (advance) s1_valid_in = 1'b0;
      else s1_valid_in = s1_valid_ff;
   end

   // line buffer: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_wr) line_mem[col_eff[AW-1:0]] <= req_tdata;
      if (acc && is_result) begin
         rd_left_ff  <= line_mem[{col_eff[AW-1:1], 1'b0}];
         rd_right_ff <= line_mem[col_eff[AW-1:0]];
      end
   end

   // configuration, position and pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hard_ff      <= HARD_MODE_RST;
         pairs_ff     <= PAIRS_RST;
         rows_ff      <= ROWS_RST;
         col_ff       <= '0;
         parity_ff    <= 1'b0;
         row_ff       <= '0;
         left_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_HARD_MODE:     hard_ff  <= csr_wdata[0];
               CSR_PAIRS_PER_ROW: pairs_ff <= csr_wdata[PAIRS_W-1:0];
               CSR_OUT_ROWS:      rows_ff  <= csr_wdata[ROWS_W-1:0];
               default: ;
            endcase
         end
         col_ff      <= col_in;
         parity_ff   <= parity_in;
         row_ff      <= row_in;
         left_ff     <= left_in;
         s1_valid_ff <= s1_valid_in;
         if (advance) rsp_valid_ff <= s1_valid_ff;
      end
   end

   // stage payload and averaged output word
   always_ff @(posedge clock) begin
      if (acc && is_result) s1_ff <= s1_in;
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= s1_ff.last_row ? '0 :
            block_avg(rd_left_ff, rd_right_ff, s1_ff.lower_left, s1_ff.lower_right,
                      s1_ff.hard);
         rsp_last_ff <= s1_ff.last_row;
         rsp_user_ff <= s1_ff.last_image;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_user_ff;

`ifndef ASSERT_OFF
   // end of image only on the end of a row
   a_image_end_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast || !rsp_tuser[0]))
      else $error("last_in_image without last_in_row");

   // the final block of a row is always transparent
   a_row_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == '0))
      else $error("row end word not zero");

   // an accepted lower-right pixel fills the averaging stage
   a_result_staged: assert property (@(posedge clock) disable iff (reset)
      (acc && is_result) |=> s1_valid_ff)
      else $error("result word lost at stage entry");

   // a full stage that cannot drain holds off the source
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !req_tready)
      else $error("source accepted while stage blocked");
`endif

endmodule : color_keyed_mipmap_downsample

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking bench for color_keyed_mipmap_downsample: random and directed pixel streams
// an in-bench predictor computes each mip word; depends on ckmd_pkg and the dut only
module tb_top;
   import ckmd_pkg::*;

   localparam int LINE_DEPTH = 256;
   localparam int LINE_AW = $clog2(LINE_DEPTH);
   localparam int SETTLE_CYCLES = 6;
   localparam int PIXEL_BUDGET = 1800;
   localparam logic [IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last_row;
      logic               last_image;
   } mip_word_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [PIXEL_W-1:0]  req_tdata;   // [15:0] src_pixel
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [PIXEL_W-1:0]  rsp_tdata;   // [15:0] mip_pixel
   logic                rsp_tlast;
   logic [0:0]          rsp_tuser;   // [0] last_in_image
   logic                csr_wen;
   logic [IDX_W-1:0]    csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   color_keyed_mipmap_downsample dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor copy of the registers and the block state
   logic                cfg_hard  = HARD_MODE_RST;
   logic [PAIRS_W-1:0]  cfg_pairs = PAIRS_RST;
   logic [ROWS_W-1:0]   cfg_rows  = ROWS_RST;
   logic [PIXEL_W-1:0]  line_buf [LINE_DEPTH];
   logic [PIXEL_W-1:0]  left_lower = '0;
   int unsigned         col_cnt = 0;
   logic                lower_row = 1'b0;
   int unsigned         row_cnt = 0;

   mip_word_type        expected_mips [$];
   int unsigned         sent_pixels = 0;
   int unsigned         errors = 0;
   bit                  req_idle_on = 1'b1;
   bit                  rsp_idle_on = 1'b1;
   int unsigned         rsp_hold_cycles = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #4000000;
      $display("color_keyed_mipmap_downsample: mismatch");
      $finish;
   end

   function automatic int unsigned eff_pairs(input logic [PAIRS_W-1:0] p);
      if (p == 0) return 1;
      if (p > LINE_DEPTH / 2) return LINE_DEPTH / 2;
      return 32'(p);
   endfunction

   // 2x2 box average with zero color key, rgb555 channels
   function automatic logic [PIXEL_W-1:0] box_average(input logic [PIXEL_W-1:0] tl,
         input logic [PIXEL_W-1:0] tr, input logic [PIXEL_W-1:0] bl,
         input logic [PIXEL_W-1:0] br, input logic hard);
      logic [PIXEL_W-1:0] px [4];
      logic [6:0]         sum_b;
      logic [6:0]         sum_g;
      logic [6:0]         sum_r;
      logic [PIXEL_W-1:0] avg;
      px[0] = tl;
      px[1] = tr;
      px[2] = bl;
      px[3] = br;
      if (!hard) begin
         for (int i = 0; i < 4; i++) px[i] = px[i] >> 1;
      end
      if (px[0] == '0) return '0;
      for (int i = 1; i < 4; i++) begin
         if (px[i] == '0) px[i] = px[0];
      end
      sum_b = 7'd2;
      sum_g = 7'd2;
      sum_r = 7'd2;
      for (int i = 0; i < 4; i++) begin
         sum_b += {2'b00, px[i][4:0]};
         sum_g += {2'b00, px[i][9:5]};
         sum_r += {2'b00, px[i][14:10]};
      end
      avg = {1'b0, sum_r[6:2], sum_g[6:2], sum_b[6:2]};
      if (!hard) avg = avg << 1;
      return avg;
   endfunction

   // advance the predictor by one source word, queue the mip word it yields
   function automatic void downsample_pixel(input logic [PIXEL_W-1:0] pix);
      int unsigned  pairs;
      int unsigned  width;
      int unsigned  rows;
      int unsigned  col;
      mip_word_type word;
      pairs = eff_pairs(cfg_pairs);
      width = 2 * pairs;
      if (cfg_rows == '0) rows = 1;
      else if (cfg_rows > ROWS_MAX) rows = 32'(ROWS_MAX);
      else rows = 32'(cfg_rows);
      // a shrunk row restarts at column 0
      if (col_cnt >= width) col_cnt = 0;
      col = col_cnt;
      if (!lower_row) begin
         line_buf[LINE_AW'(col)] = pix;
      end else if (col % 2 == 0) begin
         left_lower = pix;
      end else begin
         word.last_row = ((col >> 1) + 1 == pairs);
         word.last_image = word.last_row && (row_cnt + 1 >= rows);
         // last block of a row always comes out as zero
         word.pixel = word.last_row ? '0 :
               box_average(line_buf[LINE_AW'(col - 1)], line_buf[LINE_AW'(col)],
                           left_lower, pix, cfg_hard);
         expected_mips.push_back(word);
      end
      col_cnt = col + 1;
      if (col_cnt >= width) begin
         col_cnt = 0;
         if (!lower_row) begin
            lower_row = 1'b1;
         end else begin
            lower_row = 1'b0;
            row_cnt++;
            if (row_cnt >= rows) row_cnt = 0;
         end
      end
   endfunction

   function automatic logic [PIXEL_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0, 1: return '0;
         2: return $urandom_range(0, 1) ? 16'h8000 : 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   // send one source word, then advance the predictor on its accept
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 9) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
      downsample_pixel(pix);
      sent_pixels++;
   endtask

   // stop sending and wait until every expected word is out
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_mips.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_HARD_MODE:     cfg_hard = value[0];
         CSR_PAIRS_PER_ROW: cfg_pairs = value[PAIRS_W-1:0];
         CSR_OUT_ROWS:      cfg_rows = value[ROWS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // write all registers, unused upper bits random
   task automatic configure(input logic hard, input logic [PAIRS_W-1:0] pairs,
         input logic [ROWS_W-1:0] rows);
      write_csr(CSR_HARD_MODE, {8'($urandom), hard});
      write_csr(CSR_PAIRS_PER_ROW, {1'($urandom), pairs});
      write_csr(CSR_OUT_ROWS, rows);
      if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED, 9'($urandom));
   endtask

   // color key, zero neighbors, full-scale and high-bit-only pixels, hard mode
   task automatic test_key_hard();
      logic [PIXEL_W-1:0] pix [12] = '{
         16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF,
         16'h7FFF, 16'h7FFF, 16'h0000, 16'h0421, 16'hFFFF, 16'hFFFF};
      configure(1'b1, 8'd3, 9'd1);
      foreach (pix[i]) send_pixel(pix[i]);
      settle();
   endtask

   // soft mode: halved inputs, doubled output, key on a one-valued pixel
   task automatic test_soft_mode();
      logic [PIXEL_W-1:0] pix [16] = '{
         16'hFFFF, 16'h8000, 16'h0001, 16'h0002,
         16'h0001, 16'hABCD, 16'h0003, 16'h0004,
         16'h0001, 16'hFFFF, 16'h7FFF, 16'h7FFF,
         16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001};
      configure(1'b0, 8'd2, 9'd2);
      foreach (pix[i]) send_pixel(pix[i]);
      settle();
   endtask

   // oversized row width saturates to the line buffer; also fills every entry
   task automatic test_wide_rows();
      configure(1'b1, 8'd200, 9'd1);
      repeat (4 * LINE_DEPTH / 2) send_pixel(rand_pixel());
      settle();
   endtask

   // row widths of zero and one pair, row count of zero
   task automatic test_narrow_rows();
      configure(1'b1, 8'd0, 9'd3);
      repeat (12) send_pixel(rand_pixel());
      settle();
      configure(1'b0, 8'd1, 9'd0);
      repeat (12) send_pixel(rand_pixel());
      settle();
   endtask

   // row count above the maximum saturates, counter wraps after 256 rows
   task automatic test_tall_image();
      req_idle_on = 1'b0;
      configure(1'b1, 8'd1, 9'd511);
      repeat (4 * ROWS_MAX) send_pixel(rand_pixel());
      settle();
      req_idle_on = 1'b1;
   endtask

   // registers changed part way through a row and an image
   task automatic test_mid_row_change();
      configure(1'b1, 8'd8, 9'd4);
      repeat (16 + 5) send_pixel(rand_pixel());
      settle();
      write_csr(CSR_PAIRS_PER_ROW, 9'd2);
      repeat (20) send_pixel(rand_pixel());
      settle();
      write_csr(CSR_OUT_ROWS, 9'd1);
      repeat (16) send_pixel(rand_pixel());
      settle();
   endtask

   // receiver holds off while the sender streams at full rate
   task automatic test_backpressure();
      configure(1'($urandom), 8'd4, 9'd3);
      req_idle_on = 1'b0;
      rsp_hold_cycles = 200;
      repeat (64) send_pixel(rand_pixel());
      settle();
      req_idle_on = 1'b1;
   endtask

   // random images, mostly small, some ragged so the next setting lands mid-row
   task automatic test_random_images();
      logic [PAIRS_W-1:0] pairs;
      logic [ROWS_W-1:0]  rows;
      int unsigned        pick;
      int unsigned        count;
      while (sent_pixels < PIXEL_BUDGET) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) pairs = $urandom_range(0, 1) ? 8'd255 : 8'd128;
         else if (pick < 3) pairs = 8'($urandom_range(0, 1));
         else pairs = 8'($urandom_range(2, 12));
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0: rows = 9'd0;
               1: rows = ROWS_MAX;
               default: rows = 9'd511;
            endcase
         end else begin
            rows = 9'($urandom_range(1, 5));
         end
         count = (eff_pairs(pairs) > 16 ? 1 : $urandom_range(1, 3)) * 4 * eff_pairs(pairs);
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, 7);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         configure(1'($urandom), pairs, rows);
         repeat (count) send_pixel(rand_pixel());
         settle();
      end
   endtask

   // result side ready, with random stalls and the requested long hold
   initial begin : rsp_side
      int unsigned stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         stall = rsp_idle_on ? $urandom_range(0, 9) : 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid && rsp_hold_cycles == 0);
      end
   end

   // compare each accepted mip word with the oldest expectation
   always @(posedge clock) begin : check_mips
      mip_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_mips.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %h last %b image %b",
                  $time, rsp_tdata, rsp_tlast, rsp_tuser[0]);
            errors++;
         end else begin
            want = expected_mips.pop_front();
            if (rsp_tdata !== want.pixel) begin
               $display("%0t: mip_pixel expected %h got %h", $time, want.pixel, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.last_row) begin
               $display("%0t: last_in_row expected %b got %b", $time, want.last_row,
                     rsp_tlast);
               errors++;
            end
            if (rsp_tuser[0] !== want.last_image) begin
               $display("%0t: last_in_image expected %b got %b", $time, want.last_image,
                     rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   // main sequence
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_key_hard();
      test_soft_mode();
      test_wide_rows();
      test_narrow_rows();
      test_tall_image();
      test_mid_row_change();
      test_backpressure();
      test_random_images();
      settle();
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_mips.size() == 0) begin
         $display("color_keyed_mipmap_downsample: match");
      end else begin
         $display("color_keyed_mipmap_downsample: mismatch");
      end
      $finish;
   end

endmodule
